// ===== src/hrss_pkg.sv =====
// shared types, constants and helpers of the heart-rate session statistics block
`timescale 1ns / 1ps
package hrss_pkg;

	localparam int TIME_W  = 17;
	localparam int BPM_W   = 8;
	localparam int ZONE_W  = 10;
	localparam int RUN_W   = 9;
	localparam int MIN_W   = 11;
	localparam int MEAN_W  = 24;
	// span*100 plus half the divisor stays below 2**25 for any sample count
	localparam int NUM_W   = 25;
	localparam int BITC_W  = $clog2(NUM_W);

	localparam int DEF_MAX_SAMPLES = 512;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [BPM_W-1:0] LOW_RESET  = 8'd100;
	localparam logic [BPM_W-1:0] HIGH_RESET = 8'd160;

	localparam logic [ZONE_W-1:0] ZONE_CAP = '1;
	localparam logic [RUN_W-1:0]  RUN_CAP  = '1;

	// seconds to minutes: x/60 == (x*139811) >> 23 for every 17 bit x
	localparam int                 RECIP_W   = 18;
	localparam logic [RECIP_W-1:0] MIN_RECIP = 18'd139811;
	localparam int                 MIN_SHIFT = 23;
	localparam int                 PROD_W    = TIME_W + RECIP_W;
	localparam logic [6:0]         CENTI     = 7'd100;

	typedef enum logic {
		REG_LOW_LIMIT  = 1'b0,
		REG_HIGH_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		REP_IDLE,
		REP_PREP,
		REP_DIV,
		REP_DONE
	} rep_state_t;

	// one classified sample in the queue
	typedef struct packed {
		logic [TIME_W-1:0] t;
		logic [BPM_W-1:0]  bpm;
		logic              last;
		logic              below;
		logic              mid;
		logic              over_high;
	} item_t;

	// session totals handed to the report unit
	typedef struct packed {
		logic [ZONE_W-1:0] below;
		logic [ZONE_W-1:0] mid;
		logic [ZONE_W-1:0] above;
		logic [TIME_W-1:0] span;
		logic              two_plus;
		logic [BPM_W-1:0]  peak;
		logic [RUN_W-1:0]  runs;
		logic              intense;
		logic [TIME_W-1:0] int_first;
		logic [TIME_W-1:0] int_last;
	} snap_t;

	function automatic logic [MIN_W-1:0] prod_to_min(input logic [PROD_W-1:0] p);
		logic [PROD_W-MIN_SHIFT-1:0] m;
		m = p[PROD_W-1:MIN_SHIFT];
		if (m > (PROD_W-MIN_SHIFT)'({MIN_W{1'b1}})) begin
			return '1;
		end
		return m[MIN_W-1:0];
	endfunction

endpackage

// ===== src/hrss_front.sv =====
// front stage: takes input beats, classifies against the zone limits
`timescale 1ns / 1ps
module hrss_front
	import hrss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [TIME_W-1:0] sample_time_sec,
	input  logic [BPM_W-1:0]  sample_bpm,
	input  logic              last_sample,
	input  logic [BPM_W-1:0]  low_limit,
	input  logic [BPM_W-1:0]  high_limit,
	output logic              push_valid,
	output item_t             push_item,
	input  logic              push_full
);

	logic  valid_s1;
	item_t item_s1;
	logic  take;
	item_t cls;

	assign in_stall   = valid_s1 && push_full;
	assign take       = in_valid && !in_stall;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_comb begin
		cls.t         = sample_time_sec;
		cls.bpm       = sample_bpm;
		cls.last      = last_sample;
		cls.below     = sample_bpm < low_limit;
		cls.mid       = (sample_bpm >= low_limit) && (sample_bpm < high_limit);
		cls.over_high = sample_bpm > high_limit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!push_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= cls;
		end
	end

endmodule

// ===== src/hrss_queue.sv =====
// short queue of classified samples between front and back
`timescale 1ns / 1ps
module hrss_queue
	import hrss_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  pop_valid,
	output item_t pop_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_item  = mem_q[rd_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

// ===== src/hrss_back.sv =====
// back stage: folds samples into session totals, hands them to the report unit
`timescale 1ns / 1ps
module hrss_back
	import hrss_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	input  item_t            pop_item,
	output logic             pop,
	input  logic             rep_ready,
	output logic             rep_start,
	output snap_t            snap,
	output logic [CNT_W-1:0] rep_div
);

	logic [CNT_W-1:0]  acc_q;
	logic [ZONE_W-1:0] below_q;
	logic [ZONE_W-1:0] within_q;
	logic [ZONE_W-1:0] above_q;
	logic [TIME_W-1:0] first_q;
	logic [TIME_W-1:0] latest_q;
	logic [BPM_W-1:0]  peak_q;
	logic [RUN_W-1:0]  runs_q;
	logic              in_run_q;
	logic [TIME_W-1:0] int_first_q;
	logic [TIME_W-1:0] int_last_q;
	logic              int_seen_q;
	logic              pend_q;
	logic              room;
	logic              upd;

	assign pop       = pop_valid && !pend_q;
	assign room      = acc_q < CNT_W'(MAX_SAMPLES);
	assign upd       = pop && room;
	assign rep_start = pend_q && rep_ready;

	always_comb begin
		snap.below     = below_q;
		snap.mid       = within_q;
		snap.above     = above_q;
		snap.span      = (latest_q >= first_q) ? latest_q - first_q : '0;
		snap.two_plus  = acc_q >= CNT_W'(2);
		snap.peak      = peak_q;
		snap.runs      = runs_q;
		snap.intense   = int_seen_q;
		snap.int_first = (int_seen_q && int_first_q >= first_q) ? int_first_q - first_q : '0;
		snap.int_last  = (int_seen_q && int_last_q >= first_q) ? int_last_q - first_q : '0;
		rep_div        = acc_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			below_q     <= '0;
			within_q    <= '0;
			above_q     <= '0;
			first_q     <= '0;
			latest_q    <= '0;
			peak_q      <= '0;
			runs_q      <= '0;
			in_run_q    <= 1'b0;
			int_first_q <= '0;
			int_last_q  <= '0;
			int_seen_q  <= 1'b0;
			pend_q      <= 1'b0;
		end else if (rep_start) begin
			acc_q       <= '0;
			below_q     <= '0;
			within_q    <= '0;
			above_q     <= '0;
			first_q     <= '0;
			latest_q    <= '0;
			peak_q      <= '0;
			runs_q      <= '0;
			in_run_q    <= 1'b0;
			int_first_q <= '0;
			int_last_q  <= '0;
			int_seen_q  <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (pop && pop_item.last) begin
				pend_q <= 1'b1;
			end
			if (upd) begin
				acc_q    <= acc_q + 1'b1;
				latest_q <= pop_item.t;
				if (acc_q == '0) begin
					first_q <= pop_item.t;
				end
				if (pop_item.below) begin
					below_q <= (below_q != ZONE_CAP) ? below_q + 1'b1 : below_q;
				end else if (pop_item.mid) begin
					within_q <= (within_q != ZONE_CAP) ? within_q + 1'b1 : within_q;
				end else begin
					above_q <= (above_q != ZONE_CAP) ? above_q + 1'b1 : above_q;
				end
				if (pop_item.bpm > peak_q) begin
					peak_q <= pop_item.bpm;
				end
				if (pop_item.over_high) begin
					if (!in_run_q) begin
						runs_q <= (runs_q != RUN_CAP) ? runs_q + 1'b1 : runs_q;
					end
					in_run_q <= 1'b1;
				end else begin
					in_run_q <= 1'b0;
				end
				// intense means at or above the low limit
				if (!pop_item.below) begin
					if (!int_seen_q) begin
						int_first_q <= pop_item.t;
					end
					int_seen_q <= 1'b1;
					int_last_q <= pop_item.t;
				end
			end
		end
	end

endmodule

// ===== src/hrss_report.sv =====
// report unit: minute conversion, mean interval division, result register
`timescale 1ns / 1ps
module hrss_report
	import hrss_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              ready,
	input  snap_t             snap,
	input  logic [CNT_W-1:0]  div,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ZONE_W-1:0] count_below,
	output logic [ZONE_W-1:0] count_within,
	output logic [ZONE_W-1:0] count_above,
	output logic [MIN_W-1:0]  duration_min,
	output logic              interval_valid,
	output logic [MEAN_W-1:0] mean_interval_centisec,
	output logic [BPM_W-1:0]  peak_bpm,
	output logic [RUN_W-1:0]  high_runs,
	output logic              intense_valid,
	output logic [MIN_W-1:0]  intense_start_min,
	output logic [MIN_W-1:0]  intense_end_min
);

	rep_state_t        state_q;
	rep_state_t        state_d;
	snap_t             snap_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [NUM_W-1:0]  num_q;
	logic [BITC_W-1:0] bit_q;
	logic [PROD_W-1:0] dur_prod_q;
	logic [PROD_W-1:0] ifirst_prod_q;
	logic [PROD_W-1:0] ilast_prod_q;
	logic [CNT_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= REP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ready     = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			REP_IDLE: begin
				ready = 1'b1;
				if (start) begin
					state_d = REP_PREP;
				end
			end
			REP_PREP: begin
				state_d = REP_DIV;
			end
			REP_DIV: begin
				if (bit_q == '0) begin
					state_d = REP_DONE;
				end
			end
			REP_DONE: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = REP_IDLE;
				end
			end
			default: begin
				state_d = REP_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			REP_IDLE: begin
				if (start) begin
					snap_q <= snap;
					div_q  <= div;
				end
			end
			REP_PREP: begin
				// numerator with half the divisor added rounds half up
				num_q         <= NUM_W'(snap_q.span) * NUM_W'(CENTI) + NUM_W'(div_q >> 1);
				rem_q         <= '0;
				bit_q         <= BITC_W'(NUM_W - 1);
				dur_prod_q    <= PROD_W'(snap_q.span) * PROD_W'(MIN_RECIP);
				ifirst_prod_q <= PROD_W'(snap_q.int_first) * PROD_W'(MIN_RECIP);
				ilast_prod_q  <= PROD_W'(snap_q.int_last) * PROD_W'(MIN_RECIP);
			end
			REP_DIV: begin
				// restoring division, one quotient bit a cycle
				rem_q <= ge ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
				num_q <= {num_q[NUM_W-2:0], ge};
				bit_q <= bit_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign count_below            = snap_q.below;
	assign count_within           = snap_q.mid;
	assign count_above            = snap_q.above;
	assign duration_min           = prod_to_min(dur_prod_q);
	assign interval_valid         = snap_q.two_plus;
	assign mean_interval_centisec = snap_q.two_plus ? num_q[MEAN_W-1:0] : '0;
	assign peak_bpm               = snap_q.peak;
	assign high_runs              = snap_q.runs;
	assign intense_valid          = snap_q.intense;
	assign intense_start_min      = prod_to_min(ifirst_prod_q);
	assign intense_end_min        = prod_to_min(ilast_prod_q);

endmodule

// ===== src/heart_rate_session_stats_top.sv =====
// top level of the heart-rate session statistics block
//
//  channel   direction  handshake            payload
//  samples   in         in_valid / in_stall  sample_time_sec, sample_bpm, last_sample
//  report    out        out_valid/out_stall  zone counts, duration, mean, peak, runs, intense
//  config    in         apb psel/penable     low limit at 0x0, high limit at 0x4
//
// a sample beat passes the front register and the queue, then the back stage
// folds it into the registered totals, so plain samples flow at one per cycle
// while no pending report holds the back stage; a last-marked beat adds the
// report: a hand-over step, a setup step and the bit-serial divider, after which
// the report is valid; the divider is the limit on session rate
// the back stage holds off further beats until the report unit takes the totals,
// the queue and front register absorb beats meanwhile
// reset sets the limits to 100 and 160 bpm and clears the session totals
`timescale 1ns / 1ps
module heart_rate_session_stats_top
	import hrss_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  logic              clk,
	input  logic              arst_n,
	// sample channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [TIME_W-1:0] sample_time_sec,
	input  logic [BPM_W-1:0]  sample_bpm,
	input  logic              last_sample,
	// report channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ZONE_W-1:0] count_below,
	output logic [ZONE_W-1:0] count_within,
	output logic [ZONE_W-1:0] count_above,
	output logic [MIN_W-1:0]  duration_min,
	output logic              interval_valid,
	output logic [MEAN_W-1:0] mean_interval_centisec,
	output logic [BPM_W-1:0]  peak_bpm,
	output logic [RUN_W-1:0]  high_runs,
	output logic              intense_valid,
	output logic [MIN_W-1:0]  intense_start_min,
	output logic [MIN_W-1:0]  intense_end_min,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	logic [BPM_W-1:0] low_q;
	logic [BPM_W-1:0] high_q;
	reg_idx_t         reg_idx;
	logic             cfg_wr;

	logic             push_valid;
	item_t            push_item;
	logic             push_full;
	logic             pop;
	logic             pop_valid;
	item_t            pop_item;
	logic             rep_ready;
	logic             rep_start;
	snap_t            snap;
	logic [CNT_W-1:0] rep_div;

	// register file, word addressed, only the index bit is decoded
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_LOW_LIMIT:  prdata = 32'(low_q);
			REG_HIGH_LIMIT: prdata = 32'(high_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_RESET;
			high_q <= HIGH_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LOW_LIMIT:  low_q  <= pwdata[BPM_W-1:0];
				REG_HIGH_LIMIT: high_q <= pwdata[BPM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// front: take beats and classify against the zone limits
	hrss_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample_time_sec (sample_time_sec),
		.sample_bpm      (sample_bpm),
		.last_sample     (last_sample),
		.low_limit       (low_q),
		.high_limit      (high_q),
		.push_valid      (push_valid),
		.push_item       (push_item),
		.push_full       (push_full)
	);

	// decoupling queue
	hrss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.full       (push_full),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item)
	);

	// back: session totals
	hrss_back #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop       (pop),
		.rep_ready (rep_ready),
		.rep_start (rep_start),
		.snap      (snap),
		.rep_div   (rep_div)
	);

	// report unit with the result register
	hrss_report #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_report (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.start                  (rep_start),
		.ready                  (rep_ready),
		.snap                   (snap),
		.div                    (rep_div),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.count_below            (count_below),
		.count_within           (count_within),
		.count_above            (count_above),
		.duration_min           (duration_min),
		.interval_valid         (interval_valid),
		.mean_interval_centisec (mean_interval_centisec),
		.peak_bpm               (peak_bpm),
		.high_runs              (high_runs),
		.intense_valid          (intense_valid),
		.intense_start_min      (intense_start_min),
		.intense_end_min        (intense_end_min)
	);

	// totals are only handed over while no result waits
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rep_start |-> !out_valid)
		else $error("report started while a result is pending");

	// the report unit goes busy right after taking the totals
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rep_start |=> !rep_ready)
		else $error("report unit did not take the totals");

	// zone counts never add up to more than the capacity
	a_zone_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(count_below) + 32'(count_within) + 32'(count_above))
			<= 32'(MAX_SAMPLES))
		else $error("zone counts exceed capacity");

	// no mean without at least two samples
	a_mean_gate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !interval_valid |-> mean_interval_centisec == '0)
		else $error("mean reported without two samples");

endmodule

// ===== test/hrss_report_checker.sv =====
// checker for the heart-rate session statistics block: predicts and compares each report
`timescale 1ns / 1ps
module hrss_report_checker
	import hrss_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [TIME_W-1:0] sample_time_sec,
	input  logic [BPM_W-1:0]  sample_bpm,
	input  logic              last_sample,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [ZONE_W-1:0] count_below,
	input  logic [ZONE_W-1:0] count_within,
	input  logic [ZONE_W-1:0] count_above,
	input  logic [MIN_W-1:0]  duration_min,
	input  logic              interval_valid,
	input  logic [MEAN_W-1:0] mean_interval_centisec,
	input  logic [BPM_W-1:0]  peak_bpm,
	input  logic [RUN_W-1:0]  high_runs,
	input  logic              intense_valid,
	input  logic [MIN_W-1:0]  intense_start_min,
	input  logic [MIN_W-1:0]  intense_end_min,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                mismatch_count,
	output int                reports_pending
);

	localparam int SEC_PER_MIN   = 60;
	localparam int MIN_CAP       = 2047;
	localparam int CENTI_PER_SEC = 100;
	localparam int SHOWN_ERRORS  = 10;

	typedef struct {
		logic [ZONE_W-1:0] below;
		logic [ZONE_W-1:0] mid;
		logic [ZONE_W-1:0] above;
		logic [MIN_W-1:0]  duration;
		logic              interval_ok;
		logic [MEAN_W-1:0] mean;
		logic [BPM_W-1:0]  peak;
		logic [RUN_W-1:0]  runs;
		logic              intense_ok;
		logic [MIN_W-1:0]  intense_start;
		logic [MIN_W-1:0]  intense_end;
	} session_report_t;

	session_report_t reports_due[$];
	session_report_t want;
	session_report_t fresh;

	logic [BPM_W-1:0]  low_limit;
	logic [BPM_W-1:0]  high_limit;
	int                n_taken;
	logic [ZONE_W-1:0] n_below;
	logic [ZONE_W-1:0] n_within;
	logic [ZONE_W-1:0] n_above;
	logic [TIME_W-1:0] t_first;
	logic [TIME_W-1:0] t_latest;
	logic [TIME_W-1:0] t_int_first;
	logic [TIME_W-1:0] t_int_last;
	logic [TIME_W-1:0] span;
	logic [BPM_W-1:0]  peak;
	logic [RUN_W-1:0]  runs;
	logic              in_run;
	logic              int_seen;
	longint            divisor;
	int                errors;

	task automatic clear_session();
		n_taken     = 0;
		n_below     = '0;
		n_within    = '0;
		n_above     = '0;
		t_first     = '0;
		t_latest    = '0;
		t_int_first = '0;
		t_int_last  = '0;
		peak        = '0;
		runs        = '0;
		in_run      = 1'b0;
		int_seen    = 1'b0;
	endtask

	// time since the first sample, zero when time went backwards
	function automatic logic [TIME_W-1:0] since_first(input logic [TIME_W-1:0] t);
		return (t >= t_first) ? t - t_first : '0;
	endfunction

	function automatic logic [MIN_W-1:0] to_minutes(input logic [TIME_W-1:0] secs);
		int m;
		m = int'(secs) / SEC_PER_MIN;
		return (m > MIN_CAP) ? MIN_W'(MIN_CAP) : MIN_W'(m);
	endfunction

	task automatic check_field(input string name, input longint want_v, input longint got_v);
		if (want_v != got_v) begin
			if (errors < SHOWN_ERRORS) begin
				$display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want_v, got_v);
			end
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit  = LOW_RESET;
			high_limit = HIGH_RESET;
			clear_session();
			reports_due.delete();
			errors = 0;
			mismatch_count  <= 0;
			reports_pending <= 0;
		end else begin
			// register writes land at the access edge
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				case (reg_idx_t'(paddr[2]))
					REG_LOW_LIMIT:  low_limit = pwdata[BPM_W-1:0];
					REG_HIGH_LIMIT: high_limit = pwdata[BPM_W-1:0];
				endcase
			end

			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					check_field("report with none expected", 0, 1);
				end else begin
					want = reports_due.pop_front();
					check_field("count_below", want.below, count_below);
					check_field("count_within", want.mid, count_within);
					check_field("count_above", want.above, count_above);
					check_field("duration_min", want.duration, duration_min);
					check_field("interval_valid", want.interval_ok, interval_valid);
					check_field("mean_interval_centisec", want.mean, mean_interval_centisec);
					check_field("peak_bpm", want.peak, peak_bpm);
					check_field("high_runs", want.runs, high_runs);
					check_field("intense_valid", want.intense_ok, intense_valid);
					check_field("intense_start_min", want.intense_start, intense_start_min);
					check_field("intense_end_min", want.intense_end, intense_end_min);
				end
			end

			if (in_valid && !in_stall) begin
				// samples past capacity are dropped
				if (n_taken < MAX_SAMPLES) begin
					if (n_taken == 0) begin
						t_first = sample_time_sec;
					end
					t_latest = sample_time_sec;
					n_taken++;
					if (sample_bpm < low_limit) begin
						if (n_below != ZONE_CAP) n_below++;
					end else if (sample_bpm < high_limit) begin
						if (n_within != ZONE_CAP) n_within++;
					end else begin
						if (n_above != ZONE_CAP) n_above++;
					end
					if (sample_bpm > peak) begin
						peak = sample_bpm;
					end
					if (sample_bpm > high_limit) begin
						if (!in_run) begin
							if (runs != RUN_CAP) runs++;
							in_run = 1'b1;
						end
					end else begin
						in_run = 1'b0;
					end
					if (sample_bpm >= low_limit) begin
						if (!int_seen) begin
							t_int_first = sample_time_sec;
							int_seen    = 1'b1;
						end
						t_int_last = sample_time_sec;
					end
				end

				if (last_sample) begin
					span           = since_first(t_latest);
					fresh.below    = n_below;
					fresh.mid      = n_within;
					fresh.above    = n_above;
					fresh.duration = to_minutes(span);
					fresh.interval_ok = (n_taken >= 2);
					if (n_taken >= 2) begin
						divisor    = longint'(n_taken) - 1;
						fresh.mean = MEAN_W'((longint'(span) * CENTI_PER_SEC
							+ divisor / 2) / divisor);
					end else begin
						fresh.mean = '0;
					end
					fresh.peak       = peak;
					fresh.runs       = runs;
					fresh.intense_ok = int_seen;
					fresh.intense_start = int_seen ? to_minutes(since_first(t_int_first)) : '0;
					fresh.intense_end   = int_seen ? to_minutes(since_first(t_int_last)) : '0;
					reports_due.push_back(fresh);
					clear_session();
				end
			end

			mismatch_count  <= errors;
			reports_pending <= reports_due.size();
		end
	end

endmodule

// ===== test/heart_rate_session_stats_top_test.sv =====
// testbench top of the heart-rate session statistics block: stimulus, idling and verdict
`timescale 1ns / 1ps
module heart_rate_session_stats_top_test;
	import hrss_pkg::*;

	// longest stretch without any beat before the run is called hung
	localparam int QUIET_LIMIT  = 4000;
	// receiver hold-off that fills the block and backs up the sample channel
	localparam int HOLD_CYCLES  = 400;
	// a report leaves only after its last beat has passed the divider, give it margin
	localparam int DRAIN_CYCLES = 40;
	localparam int TIME_MAX     = (1 << TIME_W) - 1;
	localparam int DAY_LAST     = 86399;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [TIME_W-1:0] sample_time_sec;
	logic [BPM_W-1:0]  sample_bpm;
	logic              last_sample;
	logic              out_valid;
	logic              out_stall;
	logic [ZONE_W-1:0] count_below;
	logic [ZONE_W-1:0] count_within;
	logic [ZONE_W-1:0] count_above;
	logic [MIN_W-1:0]  duration_min;
	logic              interval_valid;
	logic [MEAN_W-1:0] mean_interval_centisec;
	logic [BPM_W-1:0]  peak_bpm;
	logic [RUN_W-1:0]  high_runs;
	logic              intense_valid;
	logic [MIN_W-1:0]  intense_start_min;
	logic [MIN_W-1:0]  intense_end_min;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int mismatch_count;
	int reports_pending;
	int beats_sent = 0;

	// limits as last written, only used to aim sample rates at the zone edges
	logic [BPM_W-1:0] cur_low;
	logic [BPM_W-1:0] cur_high;

	// hold_req asks the receiver for one long hold-off, no_idle turns off all gaps
	bit hold_req = 1'b0;
	bit no_idle  = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	heart_rate_session_stats_top u_top (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_stall               (in_stall),
		.sample_time_sec        (sample_time_sec),
		.sample_bpm             (sample_bpm),
		.last_sample            (last_sample),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.count_below            (count_below),
		.count_within           (count_within),
		.count_above            (count_above),
		.duration_min           (duration_min),
		.interval_valid         (interval_valid),
		.mean_interval_centisec (mean_interval_centisec),
		.peak_bpm               (peak_bpm),
		.high_runs              (high_runs),
		.intense_valid          (intense_valid),
		.intense_start_min      (intense_start_min),
		.intense_end_min        (intense_end_min),
		.psel                   (psel),
		.penable                (penable),
		.pwrite                 (pwrite),
		.paddr                  (paddr),
		.pwdata                 (pwdata),
		.prdata                 (prdata),
		.pready                 (pready)
	);

	hrss_report_checker u_check (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_stall               (in_stall),
		.sample_time_sec        (sample_time_sec),
		.sample_bpm             (sample_bpm),
		.last_sample            (last_sample),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.count_below            (count_below),
		.count_within           (count_within),
		.count_above            (count_above),
		.duration_min           (duration_min),
		.interval_valid         (interval_valid),
		.mean_interval_centisec (mean_interval_centisec),
		.peak_bpm               (peak_bpm),
		.high_runs              (high_runs),
		.intense_valid          (intense_valid),
		.intense_start_min      (intense_start_min),
		.intense_end_min        (intense_end_min),
		.psel                   (psel),
		.penable                (penable),
		.pwrite                 (pwrite),
		.paddr                  (paddr),
		.pwdata                 (pwdata),
		.pready                 (pready),
		.mismatch_count         (mismatch_count),
		.reports_pending        (reports_pending)
	);

	// gap length in cycles: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle) return 0;
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// rates cluster around both limits so every zone edge and run edge is hit
	function automatic logic [BPM_W-1:0] pick_bpm();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 20) v = int'(cur_low) + int'($urandom_range(0, 2)) - 1;
		else if (r < 40) v = int'(cur_high) + int'($urandom_range(0, 2)) - 1;
		else if (r < 48) v = ($urandom_range(0, 1) == 0) ? 0 : 255;
		else v = int'($urandom_range(0, 255));
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return BPM_W'(v);
	endfunction

	// mostly small steps forward, some long jumps, a few steps back
	function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] t);
		int r;
		int nt;
		r = $urandom_range(0, 99);
		if (r < 65) nt = int'(t) + int'($urandom_range(0, 3));
		else if (r < 85) nt = int'(t) + int'($urandom_range(4, 120));
		else if (r < 97) nt = int'(t) + int'($urandom_range(121, 4000));
		else nt = int'(t) - int'($urandom_range(1, 200));
		if (nt < 0) nt = 0;
		if (nt > TIME_MAX) nt = TIME_MAX;
		return TIME_W'(nt);
	endfunction

	// one sample beat: optional gap, then hold the payload until it is taken
	task automatic send_beat(input logic [TIME_W-1:0] t, input logic [BPM_W-1:0] bpm,
			input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		sample_time_sec <= t;
		sample_bpm      <= bpm;
		last_sample     <= last;
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	task automatic play_session(input int n);
		logic [TIME_W-1:0] t;
		int i;
		// a tenth of the sessions start past the end of the day, up to the field limit
		if ($urandom_range(0, 9) == 0) t = TIME_W'($urandom_range(DAY_LAST + 1, TIME_MAX));
		else t = TIME_W'($urandom_range(0, DAY_LAST));
		for (i = 0; i < n; i++) begin
			send_beat(t, pick_bpm(), i == n - 1);
			t = next_time(t);
		end
	endtask

	// random sessions until about the given number of beats went in
	task automatic run_sessions(input int budget);
		int target;
		int r;
		target = beats_sent + budget;
		while (beats_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 10) play_session(1);
			else if (r < 20) play_session(2);
			else if (r < 85) play_session($urandom_range(3, 16));
			else play_session($urandom_range(17, 60));
		end
	endtask

	// wait until every report is out and the block has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reports_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write: setup cycle, access cycle, done on the edge with pready
	task automatic write_limit(input reg_idx_t idx, input logic [BPM_W-1:0] v);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (idx == REG_LOW_LIMIT) cur_low = v;
		else cur_high = v;
	endtask

	task automatic new_limits(input logic [BPM_W-1:0] lo, input logic [BPM_W-1:0] hi);
		settle();
		write_limit(REG_LOW_LIMIT, lo);
		write_limit(REG_HIGH_LIMIT, hi);
	endtask

	// watchdog: ends the run when no beat moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// report receiver: random stalls, and one long hold-off on request
	initial begin : receiver
		int len;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				len = pick_gap();
				if (len > 0) begin
					out_stall <= 1'b1;
					repeat (len) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin : stimulus
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		sample_time_sec <= '0;
		sample_bpm      <= '0;
		last_sample     <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		cur_low  = LOW_RESET;
		cur_high = HIGH_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sessions under the reset limits of 100 and 160 bpm
		// lone sample at time zero and rate zero: no interval, nothing intense
		send_beat('0, 8'd0, 1'b1);
		// lone sample at the top of both fields
		send_beat(TIME_W'(TIME_MAX), 8'd255, 1'b1);
		// every zone edge, a rate equal to the high limit that opens no run, two runs
		send_beat(17'd5, 8'd99, 1'b0);
		send_beat(17'd10, 8'd100, 1'b0);
		send_beat(17'd70, 8'd159, 1'b0);
		send_beat(17'd130, 8'd160, 1'b0);
		send_beat(17'd131, 8'd161, 1'b0);
		send_beat(17'd132, 8'd200, 1'b0);
		send_beat(17'd133, 8'd150, 1'b0);
		send_beat(17'd200, 8'd170, 1'b1);
		// span over the whole field: minutes saturate, largest mean
		send_beat('0, 8'd50, 1'b0);
		send_beat(TIME_W'(TIME_MAX), 8'd120, 1'b1);
		// time runs backwards below the session start
		send_beat(17'd1000, 8'd120, 1'b0);
		send_beat(17'd400, 8'd130, 1'b0);
		send_beat(17'd300, 8'd90, 1'b1);
		// first intense sample two hours in
		send_beat('0, 8'd10, 1'b0);
		send_beat(17'd3600, 8'd30, 1'b0);
		send_beat(17'd7200, 8'd110, 1'b1);
		// mean of 66.67 rounds up to 67
		send_beat(17'd50000, 8'd100, 1'b0);
		send_beat(17'd50000, 8'd100, 1'b0);
		send_beat(17'd50001, 8'd100, 1'b0);
		send_beat(17'd50002, 8'd100, 1'b1);

		// session that exactly fills the capacity
		play_session(DEF_MAX_SAMPLES);
		run_sessions(100);

		// both limits at zero, with the receiver holding off while short sessions pile up
		new_limits(8'd0, 8'd0);
		hold_req = 1'b1;
		repeat (40) play_session($urandom_range(1, 2));
		run_sessions(80);

		new_limits(8'd255, 8'd255);
		run_sessions(100);

		// low limit above the high one, and no gaps on either side
		new_limits(8'd200, 8'd50);
		no_idle = 1'b1;
		run_sessions(100);
		no_idle = 1'b0;

		new_limits(8'd0, 8'd255);
		run_sessions(100);

		// session past the capacity: the tail is dropped, the last beat still reports
		new_limits(BPM_W'($urandom_range(60, 120)), BPM_W'($urandom_range(130, 200)));
		play_session(DEF_MAX_SAMPLES + 18);
		run_sessions(80);

		new_limits(BPM_W'($urandom), BPM_W'($urandom));
		run_sessions(80);

		new_limits(8'd255, 8'd0);
		run_sessions(80);

		settle();
		if (mismatch_count == 0 && reports_pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
